// ----- hdl/first_fit_page_range_allocator_defines.svh -----
// Assertion helpers used by the allocator control module.
`ifndef FIRST_FIT_PAGE_RANGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_PAGE_RANGE_ALLOCATOR_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define FFPRA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define FFPRA_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hdl/ffpra_pkg.sv -----
package ffpra_pkg;

   localparam int MAX_RANGES = 64;
   localparam int PAGE_SHIFT = 12;
   localparam int ADDR_BITS  = 32;

   localparam int IDX_W   = $clog2(MAX_RANGES);
   localparam int CNT_W   = $clog2(MAX_RANGES + 1);
   localparam int SCAN_W  = $clog2(MAX_RANGES + 3);
   localparam int BASE_W  = 20;
   localparam int PAGES_W = 21;
   localparam int END_W   = PAGES_W + 1;
   localparam int OWNER_W = 8;
   localparam int VPN_W   = ADDR_BITS - PAGE_SHIFT;
   localparam int PAGE_LIMIT = (VPN_W >= 20) ? (1 << 20) : (1 << VPN_W);

   typedef enum logic [1:0] {
      ACT_ALLOC  = 2'd0,
      ACT_FREE   = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_SETOWN = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_INVALID = 3'd1,
      ST_BUSY    = 3'd2,
      ST_NOSPACE = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      REG_AREA_BASE = 2'd0,
      REG_AREA_TOP  = 2'd1,
      REG_RSV_BASE  = 2'd2,
      REG_RSV_TOP   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [BASE_W-1:0]  base;
      logic [PAGES_W-1:0] pages;
      logic               used;
      logic [OWNER_W-1:0] owner;
   } entry_type;

   typedef struct packed {
      logic start;
      logic init_step;
      logic scan;
      logic cap;
      logic exec;
      logic move;
      logic wra;
      logic wrb;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic cfg_wr;
      logic init_done;
      logic scan_end;
      logic move_done;
   } sts_type;

   function automatic logic [ADDR_BITS-1:0] byte_of(input logic [BASE_W-1:0] page);
      logic [BASE_W+PAGE_SHIFT-1:0] full;
      full = {page, {PAGE_SHIFT{1'b0}}};
      return ADDR_BITS'(full);
   endfunction

endpackage

// ----- hdl/ffpra_ram.sv -----
module ffpra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ----- hdl/ffpra_datapath.sv -----
module ffpra_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  ffpra_pkg::cmd_type               cmd,
   output ffpra_pkg::sts_type               sts,
   input  logic [1:0]                       req_action,
   input  logic [20:0]                      req_page_count,
   input  logic [ffpra_pkg::ADDR_BITS-1:0]  req_address,
   input  logic [7:0]                       req_owner_tag,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [20:0]                      csr_data,
   output logic [2:0]                       rsp_status,
   output logic [ffpra_pkg::ADDR_BITS-1:0]  rsp_base_address,
   output logic                             rsp_found,
   output logic [7:0]                       rsp_found_owner
);
   import ffpra_pkg::*;

   // configuration
   logic [BASE_W-1:0]  area_base_ff;
   logic [PAGES_W-1:0] area_top_ff, rsv_base_ff, rsv_top_ff;
   logic [PAGES_W-1:0] hi, lo, rb0, rb, rt0, rt;
   entry_type          piece [4];
   logic [3:0]         piece_ok;
   logic [1:0]         ic_ff;

   // table
   logic [CNT_W-1:0]   n_ff;
   logic               ram_we, ram_re;
   logic [IDX_W-1:0]   ram_waddr, ram_raddr;
   entry_type          ram_wdata, rdata;

   // request
   action_type         act_ff;
   logic [PAGES_W-1:0] cnt_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [OWNER_W-1:0] tag_ff;
   logic [VPN_W-1:0]   page;
   logic               offs_zero;

   // scan
   logic [SCAN_W-1:0]  sc_ff, chk_ff;
   logic               pv_ff, hit_ff;
   logic [IDX_W-1:0]   k_ff;
   entry_type          cur_ff, prev_ff, nxt_ff;
   logic [END_W-1:0]   e_end;
   logic               cand, scan_hit, scan_miss;

   // plan
   status_type         x_status, res_status_ff;
   logic [ADDR_BITS-1:0] x_base, res_base_ff;
   logic               x_found, res_found_ff;
   logic [OWNER_W-1:0] x_owner, res_owner_ff;
   logic               x_wa_en, x_wb_en, wa_en_ff, wb_en_ff;
   logic [IDX_W-1:0]   x_wa_addr, x_wb_addr, wa_addr_ff, wb_addr_ff;
   entry_type          x_wa_data, x_wb_data, wa_data_ff, wb_data_ff;
   logic [SCAN_W-1:0]  x_mv_cnt, x_mv_src;
   logic               x_mv_up;
   logic [1:0]         x_mv_d;
   logic [CNT_W-1:0]   x_n;
   logic [SCAN_W-1:0]  k_s, n_s, t_s, src_s;
   logic               pm, nm;
   logic [1:0]         d;
   logic [PAGES_W:0]   split_sum;

   // move engine
   logic [SCAN_W-1:0]  mv_cnt_ff, mv_src_ff, dst_ff;
   logic               mv_up_ff, pend_ff;
   logic [1:0]         mv_d_ff;

   ffpra_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_RANGES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         area_base_ff <= BASE_W'(4);
         area_top_ff  <= PAGES_W'(1 << 20);
         rsv_base_ff  <= '0;
         rsv_top_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            REG_AREA_BASE: area_base_ff <= csr_data[BASE_W-1:0];
            REG_AREA_TOP:  area_top_ff  <= csr_data;
            REG_RSV_BASE:  rsv_base_ff  <= csr_data;
            REG_RSV_TOP:   rsv_top_ff   <= csr_data;
            default:       area_top_ff  <= area_top_ff;
         endcase
      end
   end

   // clamp the layout into the managed area
   always_comb begin
      hi  = (area_top_ff > PAGES_W'(PAGE_LIMIT)) ? PAGES_W'(PAGE_LIMIT) : area_top_ff;
      lo  = ({1'b0, area_base_ff} > hi) ? hi : {1'b0, area_base_ff};
      rb0 = (rsv_base_ff < lo) ? lo : rsv_base_ff;
      rb  = (rb0 > hi) ? hi : rb0;
      rt0 = (rsv_top_ff < rb) ? rb : rsv_top_ff;
      rt  = (rt0 > hi) ? hi : rt0;
      piece[0] = '{base: lo[BASE_W-1:0], pages: rb - lo, used: 1'b0, owner: '0};
      piece[1] = '{base: rb[BASE_W-1:0], pages: rt - rb, used: 1'b1, owner: '0};
      piece[2] = '{base: rt[BASE_W-1:0], pages: hi - rt, used: 1'b0, owner: '0};
      piece[3] = '0;
      piece_ok = {1'b0, hi > rt, rt > rb, rb > lo};
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         act_ff  <= action_type'(req_action);
         cnt_ff  <= req_page_count;
         addr_ff <= req_address;
         tag_ff  <= req_owner_tag;
      end
   end

   assign page      = addr_ff[ADDR_BITS-1:PAGE_SHIFT];
   assign offs_zero = (addr_ff[PAGE_SHIFT-1:0] == '0);

   always_comb begin
      e_end = END_W'(rdata.base) + END_W'(rdata.pages);
      if (act_ff == ACT_ALLOC) begin
         cand = !rdata.used && (rdata.pages >= cnt_ff);
      end else begin
         cand = rdata.used && (END_W'(page) >= END_W'(rdata.base)) && (END_W'(page) < e_end);
      end
      scan_hit  = cmd.scan && pv_ff && cand;
      scan_miss = cmd.scan && !pv_ff && (sc_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff  <= '0;
         pv_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else if (cmd.start) begin
         sc_ff  <= '0;
         pv_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else if (cmd.scan) begin
         sc_ff  <= sc_ff + 1'b1;
         pv_ff  <= (sc_ff < SCAN_W'(n_ff));
         chk_ff <= sc_ff;
         if (scan_hit) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_hit) begin
         cur_ff <= rdata;
         k_ff   <= chk_ff[IDX_W-1:0];
      end else if (cmd.scan && pv_ff) begin
         prev_ff <= rdata;
      end
      // the read issued with the hit returns the entry after it
      if (cmd.cap) begin
         nxt_ff <= rdata;
      end
   end

   // decide the result and the table update
   always_comb begin
      x_status  = ST_OK;
      x_base    = '0;
      x_found   = 1'b0;
      x_owner   = '0;
      x_wa_en   = 1'b0;
      x_wa_addr = k_ff;
      x_wa_data = cur_ff;
      x_wb_en   = 1'b0;
      x_wb_addr = k_ff;
      x_wb_data = cur_ff;
      x_mv_cnt  = '0;
      x_mv_src  = '0;
      x_mv_up   = 1'b0;
      x_mv_d    = 2'd1;
      x_n       = n_ff;
      k_s       = SCAN_W'(k_ff);
      n_s       = SCAN_W'(n_ff);
      pm = (k_ff != '0) && !prev_ff.used &&
           (END_W'(prev_ff.base) + END_W'(prev_ff.pages) == END_W'(cur_ff.base));
      nm = (k_s + 1'b1 < n_s) && !nxt_ff.used &&
           (END_W'(cur_ff.base) + END_W'(cur_ff.pages) == END_W'(nxt_ff.base));
      t_s       = pm ? (k_s - 1'b1) : k_s;
      d         = (pm && nm) ? 2'd2 : 2'd1;
      src_s     = t_s + 1'b1 + SCAN_W'(d);
      split_sum = {1'b0, cur_ff.base} + {1'b0, cnt_ff};
      unique case (act_ff)
         ACT_ALLOC: begin
            priority if (cnt_ff == '0) begin
               x_status = ST_INVALID;
            end else if (!hit_ff) begin
               x_status = ST_NOSPACE;
            end else if (cur_ff.pages == cnt_ff) begin
               x_wa_en   = 1'b1;
               x_wa_data = '{base: cur_ff.base, pages: cur_ff.pages, used: 1'b1, owner: '0};
               x_base    = byte_of(cur_ff.base);
            end else if (n_ff == CNT_W'(MAX_RANGES)) begin
               x_status = ST_FULL;
            end else begin
               // open a slot after the pick, then write both halves
               x_mv_up   = 1'b1;
               x_mv_src  = n_s - 1'b1;
               x_mv_cnt  = n_s - 1'b1 - k_s;
               x_wa_en   = 1'b1;
               x_wa_addr = k_ff + 1'b1;
               x_wa_data = '{base: split_sum[BASE_W-1:0], pages: cur_ff.pages - cnt_ff,
                             used: 1'b0, owner: '0};
               x_wb_en   = 1'b1;
               x_wb_data = '{base: cur_ff.base, pages: cnt_ff, used: 1'b1, owner: '0};
               x_n       = n_ff + 1'b1;
               x_base    = byte_of(cur_ff.base);
            end
         end
         ACT_FREE: begin
            priority if (!hit_ff || !offs_zero || (END_W'(cur_ff.base) != END_W'(page))) begin
               x_status = ST_INVALID;
            end else if (cur_ff.owner != '0) begin
               x_status = ST_BUSY;
            end else begin
               x_base    = byte_of(cur_ff.base);
               x_wa_en   = 1'b1;
               x_wa_addr = t_s[IDX_W-1:0];
               priority if (pm && nm) begin
                  x_wa_data = '{base: prev_ff.base,
                                pages: prev_ff.pages + cur_ff.pages + nxt_ff.pages,
                                used: 1'b0, owner: '0};
               end else if (pm) begin
                  x_wa_data = '{base: prev_ff.base, pages: prev_ff.pages + cur_ff.pages,
                                used: 1'b0, owner: '0};
               end else if (nm) begin
                  x_wa_data = '{base: cur_ff.base, pages: cur_ff.pages + nxt_ff.pages,
                                used: 1'b0, owner: '0};
               end else begin
                  x_wa_data = '{base: cur_ff.base, pages: cur_ff.pages,
                                used: 1'b0, owner: '0};
               end
               if (pm || nm) begin
                  // close the gap left by the merged entries
                  x_mv_d   = d;
                  x_mv_src = src_s;
                  x_mv_cnt = (src_s < n_s) ? (n_s - src_s) : '0;
                  x_n      = n_ff - CNT_W'(d);
               end
            end
         end
         ACT_LOOKUP: begin
            if (hit_ff) begin
               x_found = 1'b1;
               x_owner = cur_ff.owner;
               x_base  = byte_of(cur_ff.base);
            end
         end
         ACT_SETOWN: begin
            if (!hit_ff) begin
               x_status = ST_INVALID;
            end else begin
               x_wa_en   = 1'b1;
               x_wa_data = '{base: cur_ff.base, pages: cur_ff.pages, used: 1'b1,
                             owner: tag_ff};
               x_base    = byte_of(cur_ff.base);
            end
         end
         default: x_status = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_status_ff <= x_status;
         res_base_ff   <= x_base;
         res_found_ff  <= x_found;
         res_owner_ff  <= x_owner;
         wa_addr_ff    <= x_wa_addr;
         wa_data_ff    <= x_wa_data;
         wb_addr_ff    <= x_wb_addr;
         wb_data_ff    <= x_wb_data;
      end
      if (cmd.rsp_load) begin
         rsp_status       <= res_status_ff;
         rsp_base_address <= res_base_ff;
         rsp_found        <= res_found_ff;
         rsp_found_owner  <= res_owner_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff      <= '0;
         ic_ff     <= '0;
         wa_en_ff  <= 1'b0;
         wb_en_ff  <= 1'b0;
         mv_cnt_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            n_ff  <= '0;
            ic_ff <= '0;
         end else if (cmd.init_step) begin
            ic_ff <= ic_ff + 1'b1;
            if (piece_ok[ic_ff]) begin
               n_ff <= n_ff + 1'b1;
            end
         end else if (cmd.exec) begin
            n_ff <= x_n;
         end
         if (cmd.exec) begin
            wa_en_ff  <= x_wa_en;
            wb_en_ff  <= x_wb_en;
            mv_cnt_ff <= x_mv_cnt;
            mv_src_ff <= x_mv_src;
            mv_up_ff  <= x_mv_up;
            mv_d_ff   <= x_mv_d;
            pend_ff   <= 1'b0;
         end else if (cmd.move) begin
            if (mv_cnt_ff != '0) begin
               mv_cnt_ff <= mv_cnt_ff - 1'b1;
               mv_src_ff <= mv_up_ff ? (mv_src_ff - 1'b1) : (mv_src_ff + 1'b1);
               dst_ff    <= mv_up_ff ? (mv_src_ff + 1'b1) : (mv_src_ff - SCAN_W'(mv_d_ff));
               pend_ff   <= 1'b1;
            end else begin
               pend_ff <= 1'b0;
            end
         end
      end
   end

   always_comb begin
      ram_re    = cmd.scan || (cmd.move && (mv_cnt_ff != '0));
      ram_raddr = cmd.move ? mv_src_ff[IDX_W-1:0] : sc_ff[IDX_W-1:0];
      ram_we    = 1'b0;
      ram_waddr = n_ff[IDX_W-1:0];
      ram_wdata = piece[ic_ff];
      priority if (cmd.init_step) begin
         ram_we = piece_ok[ic_ff];
      end else if (cmd.move) begin
         ram_we    = pend_ff;
         ram_waddr = dst_ff[IDX_W-1:0];
         ram_wdata = rdata;
      end else if (cmd.wra) begin
         ram_we    = wa_en_ff;
         ram_waddr = wa_addr_ff;
         ram_wdata = wa_data_ff;
      end else if (cmd.wrb) begin
         ram_we    = wb_en_ff;
         ram_waddr = wb_addr_ff;
         ram_wdata = wb_data_ff;
      end
   end

   always_comb begin
      sts.cfg_wr    = csr_we;
      sts.init_done = (ic_ff == 2'd2);
      sts.scan_end  = scan_hit || scan_miss;
      sts.move_done = (mv_cnt_ff == '0) && !pend_ff;
   end

endmodule

// ----- hdl/ffpra_ctrl.sv -----
module ffpra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ffpra_pkg::sts_type sts,
   output ffpra_pkg::cmd_type cmd
);
   import ffpra_pkg::*;
   `include "first_fit_page_range_allocator_defines.svh"

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_INIT = 9'b000000010,
      ST_SCAN = 9'b000000100,
      ST_CAP  = 9'b000001000,
      ST_EXEC = 9'b000010000,
      ST_MOVE = 9'b000100000,
      ST_WRA  = 9'b001000000,
      ST_WRB  = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   assign req_ready = (state_ff == ST_IDLE) && !sts.cfg_wr;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (sts.cfg_wr) begin
               state_in = ST_INIT;
            end else if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (!sts.cfg_wr && sts.init_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_end) begin
               state_in = ST_CAP;
            end
         end
         ST_CAP: begin
            cmd.cap  = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            if (sts.move_done) begin
               state_in = ST_WRA;
            end
         end
         ST_WRA: begin
            cmd.wra  = 1'b1;
            state_in = ST_WRB;
         end
         ST_WRB: begin
            cmd.wrb  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the previous response has left
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `FFPRA_ASSERT_NEXT(a_accept_scans, req_valid && req_ready, state_ff == ST_SCAN, "accepted transaction did not start a scan")
   `FFPRA_ASSERT_NEXT(a_load_shows, cmd.rsp_load, rsp_valid_ff, "loaded response not presented")
   `FFPRA_ASSERT_NEXT(a_move_holds, (state_ff == ST_MOVE) && !sts.move_done, state_ff == ST_MOVE, "left entry move early")

endmodule

// ----- hdl/first_fit_page_range_allocator.sv -----
// Sequence: an accepted request scans the table up to the hit at entry k, or over all n live
// ranges on a miss, then plans, shifts entries displaced by a split or merge, and writes.
// Only one transaction is in flight at a time; the scan goes through the single read port of
// the range table, and the next request is taken while a response waits.
// Reset: synchronous, active high; the initial layout (up to three ranges) is then written,
// and a register write while idle rebuilds it the same way before requests are taken.
module first_fit_page_range_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_action,
   input  logic [20:0]                     req_page_count,
   input  logic [ffpra_pkg::ADDR_BITS-1:0] req_address,
   input  logic [7:0]                      req_owner_tag,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_status,
   output logic [ffpra_pkg::ADDR_BITS-1:0] rsp_base_address,
   output logic                            rsp_found,
   output logic [7:0]                      rsp_found_owner,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [20:0]                     csr_data
);
   import ffpra_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ffpra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffpra_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_action),
      .req_page_count   (req_page_count),
      .req_address      (req_address),
      .req_owner_tag    (req_owner_tag),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_status       (rsp_status),
      .rsp_base_address (rsp_base_address),
      .rsp_found        (rsp_found),
      .rsp_found_owner  (rsp_found_owner)
   );

endmodule
